// ===== hdl/rar_pkg.sv =====
package rar_pkg;

  // Operation codes carried on s_tuser.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes carried on m_tuser.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_NAN = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL1  = 9'b000000010,
    ST_MUL2  = 9'b000000100,
    ST_MUL3  = 9'b000001000,
    ST_ADD   = 9'b000010000,
    ST_CHECK = 9'b000100000,
    ST_GCD   = 9'b001000000,
    ST_DIVN  = 9'b010000000,
    ST_DIVD  = 9'b100000000
  } state_t;

endpackage

// ===== hdl/rational_arith_reduce.sv =====
// Each input word passes through the sequencer states MUL1, MUL2, MUL3, ADD, CHECK, GCD (the
// Euclid remainder steps), DIVN and DIVD before the output register loads; a zero denominator
// or a zero numerator goes from CHECK straight to a single DIVD step.
// A new word is taken only once the last has been loaded, as s_tready is high only while the
// sequencer is idle; one shared multiplier and one restoring divider (one quotient bit per
// cycle, save while the output stalls) do all the work. Reset is synchronous and active high.
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0: a_numerator, a_denominator, b_numerator, b_denominator.
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
  // Fields from bit 0: operation.
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0: result_numerator, result_denominator, zero fill.
  output logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0] m_tdata,
  // Fields from bit 0: status.
  output logic [0:0] m_tuser
);

  localparam int W      = OPERAND_WIDTH;
  localparam int NB     = 2 * W;
  localparam int DW     = 2 * W - 2;
  localparam int OUT_TW = ((4 * W - 2 + 7) / 8) * 8;
  localparam int PAD    = OUT_TW - NB - DW;
  localparam int CW     = $clog2(NB);

  localparam logic [NB-1:0] NUM_MAX = {1'b0, {(NB-1){1'b1}}};
  localparam logic [NB-1:0] DEN_MAX = {2'b00, {DW{1'b1}}};

  rar_pkg::state_t state;

  // Latched factor pairs and product signs.
  logic [W-1:0] fa1, fb1, fa2, fb2, fa3, fb3;
  logic         sgn1, sgn2, sgn3;

  // Products and intermediate magnitudes.
  logic [NB-1:0] p1, p2, den_mag, num_mag;
  logic          num_neg, res_neg, res_nan;
  logic [NB-1:0] qn;

  // Shared divider registers.
  logic [NB-1:0] dv_rem, dv_q, dv_d;
  logic [CW-1:0] cnt;

  // Input decoding.
  logic [W-1:0] an_raw, ad_raw, bn_raw, bd_raw;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic         bn_neg;

  assign an_raw = s_tdata[W-1:0];
  assign ad_raw = s_tdata[2*W-1:W];
  assign bn_raw = s_tdata[3*W-1:2*W];
  assign bd_raw = s_tdata[4*W-1:3*W];

  // Magnitudes of the operands; the most negative code decodes to its true size.
  assign an_mag = an_raw[W-1] ? (~an_raw + 1'b1) : an_raw;
  assign ad_mag = ad_raw[W-1] ? (~ad_raw + 1'b1) : ad_raw;
  assign bn_mag = bn_raw[W-1] ? (~bn_raw + 1'b1) : bn_raw;
  assign bd_mag = bd_raw[W-1] ? (~bd_raw + 1'b1) : bd_raw;
  assign bn_neg = bn_raw[W-1] ^ (s_tuser == rar_pkg::OP_SUB);

  assign s_tready = (state == rar_pkg::ST_IDLE);

  // Shared multiplier operand selection.
  logic [W-1:0]  mul_x, mul_y;
  logic [NB-1:0] prod;

  always_comb begin
    unique case (state)
      rar_pkg::ST_MUL2: begin
        mul_x = fa2;
        mul_y = fb2;
      end
      rar_pkg::ST_MUL3: begin
        mul_x = fa3;
        mul_y = fb3;
      end
      default: begin
        mul_x = fa1;
        mul_y = fb1;
      end
    endcase
  end

  assign prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  // Signed-magnitude sum of the two cross products.
  logic [NB-1:0] sum_mag;
  logic          sum_neg;

  always_comb begin
    if (sgn1 == sgn2) begin
      sum_mag = p1 + p2;
      sum_neg = sgn1;
    end else if (p1 >= p2) begin
      sum_mag = p1 - p2;
      sum_neg = sgn1;
    end else begin
      sum_mag = p2 - p1;
      sum_neg = sgn2;
    end
  end

  // One restoring divider step: one quotient bit per cycle, save while the last step waits for the output.
  logic [NB:0]   dv_t;
  logic          dv_ge;
  logic [NB-1:0] rem_next, q_next;
  logic          last;

  assign dv_t     = {dv_rem, dv_q[NB-1]};
  assign dv_ge    = (dv_t >= {1'b0, dv_d});
  assign rem_next = dv_ge ? NB'(dv_t - {1'b0, dv_d}) : dv_t[NB-1:0];
  assign q_next   = {dv_q[NB-2:0], dv_ge};
  assign last     = (cnt == CW'(NB - 1));

  // Saturation and sign for the output word.
  logic [NB-1:0] nsat, nout;

  assign nsat = (qn > NUM_MAX) ? NUM_MAX : qn;
  assign nout = res_neg ? (~nsat + 1'b1) : nsat;

  // The output register takes a word on the last denominator step once it is free.
  logic out_load;

  assign out_load = (state == rar_pkg::ST_DIVD) && last && (!m_tvalid || m_tready);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rar_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        rar_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            // Pick factor pairs so every operation forms p1 + p2 over p3.
            unique case (s_tuser)
              rar_pkg::OP_MUL: begin
                fa1 <= an_mag; fb1 <= bn_mag; sgn1 <= an_raw[W-1] ^ bn_raw[W-1];
                fa2 <= '0;     fb2 <= '0;     sgn2 <= 1'b0;
                fa3 <= ad_mag; fb3 <= bd_mag; sgn3 <= ad_raw[W-1] ^ bd_raw[W-1];
              end
              rar_pkg::OP_DIV: begin
                fa1 <= an_mag; fb1 <= bd_mag; sgn1 <= an_raw[W-1] ^ bd_raw[W-1];
                fa2 <= '0;     fb2 <= '0;     sgn2 <= 1'b0;
                fa3 <= ad_mag; fb3 <= bn_mag; sgn3 <= ad_raw[W-1] ^ bn_raw[W-1];
              end
              default: begin
                fa1 <= an_mag; fb1 <= bd_mag; sgn1 <= an_raw[W-1] ^ bd_raw[W-1];
                fa2 <= bn_mag; fb2 <= ad_mag; sgn2 <= bn_neg ^ ad_raw[W-1];
                fa3 <= ad_mag; fb3 <= bd_mag; sgn3 <= ad_raw[W-1] ^ bd_raw[W-1];
              end
            endcase
            state <= rar_pkg::ST_MUL1;
          end
        end
        rar_pkg::ST_MUL1: begin
          p1    <= prod;
          state <= rar_pkg::ST_MUL2;
        end
        rar_pkg::ST_MUL2: begin
          p2    <= prod;
          state <= rar_pkg::ST_MUL3;
        end
        rar_pkg::ST_MUL3: begin
          den_mag <= prod;
          state   <= rar_pkg::ST_ADD;
        end
        rar_pkg::ST_ADD: begin
          num_mag <= sum_mag;
          num_neg <= sum_neg;
          state   <= rar_pkg::ST_CHECK;
        end
        rar_pkg::ST_CHECK: begin
          if (den_mag == '0) begin
            // Zero denominator: NaN with both fields zero.
            res_nan <= rar_pkg::STATUS_NAN;
            res_neg <= 1'b0;
            qn      <= '0;
            state   <= rar_pkg::ST_DIVD;
            cnt     <= CW'(NB - 1);
            dv_q    <= '0;
            dv_rem  <= '0;
            dv_d    <= NB'(1);
          end else if (num_mag == '0) begin
            // Zero result reads as 0/1: the single step against a zero divisor gives 1.
            res_nan <= rar_pkg::STATUS_OK;
            res_neg <= 1'b0;
            qn      <= '0;
            state   <= rar_pkg::ST_DIVD;
            cnt     <= CW'(NB - 1);
            dv_q    <= '0;
            dv_rem  <= '0;
            dv_d    <= '0;
          end else begin
            res_nan <= rar_pkg::STATUS_OK;
            res_neg <= num_neg ^ sgn3;
            dv_rem  <= '0;
            dv_q    <= num_mag;
            dv_d    <= den_mag;
            cnt     <= '0;
            state   <= rar_pkg::ST_GCD;
          end
        end
        rar_pkg::ST_GCD: begin
          if (last) begin
            dv_rem <= '0;
            cnt    <= '0;
            if (rem_next == '0) begin
              // The divisor is the GCD; keep it and divide the numerator.
              dv_q  <= num_mag;
              state <= rar_pkg::ST_DIVN;
            end else begin
              dv_q <= dv_d;
              dv_d <= rem_next;
            end
          end else begin
            dv_rem <= rem_next;
            dv_q   <= q_next;
            cnt    <= cnt + 1'b1;
          end
        end
        rar_pkg::ST_DIVN: begin
          if (last) begin
            qn     <= q_next;
            dv_rem <= '0;
            dv_q   <= den_mag;
            cnt    <= '0;
            state  <= rar_pkg::ST_DIVD;
          end else begin
            dv_rem <= rem_next;
            dv_q   <= q_next;
            cnt    <= cnt + 1'b1;
          end
        end
        rar_pkg::ST_DIVD: begin
          if (!last) begin
            dv_rem <= rem_next;
            dv_q   <= q_next;
            cnt    <= cnt + 1'b1;
          end else if (out_load) begin
            // Quotient bit lands in the output word once the output register is free.
            if (res_nan == rar_pkg::STATUS_NAN) begin
              m_tdata <= {{PAD{1'b0}}, {DW{1'b0}}, {NB{1'b0}}};
            end else begin
              m_tdata <= {{PAD{1'b0}}, (q_next > DEN_MAX) ? DEN_MAX[DW-1:0] : q_next[DW-1:0],
                          nout};
            end
            m_tuser <= res_nan;
            state   <= rar_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rar_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rar_checker.sv =====
module rar_checker #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0] m_tdata,
  input logic [0:0] m_tuser
);

  localparam int NB = 2 * OPERAND_WIDTH;
  localparam int DW = 2 * OPERAND_WIDTH - 2;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // A NaN word carries zero fields.
  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == rar_pkg::STATUS_NAN) |->
      (m_tdata[NB-1:0] == '0) && (m_tdata[NB+DW-1:NB] == '0))
    else $error("NaN word with nonzero fields");

  // A valid result has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == rar_pkg::STATUS_OK) |-> (m_tdata[NB+DW-1:NB] != '0))
    else $error("valid word with zero denominator");

  // One word is in work at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

endmodule

bind rational_arith_reduce rar_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rar_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
